// ===== src/upsc_pkg.sv =====
// Shared types and constants for the integer pixel upscaler.
package upsc_pkg;

   typedef struct packed {
      logic       req_type;
      logic [7:0] blue_in;
      logic [7:0] green_in;
      logic [7:0] red_in;
   } req_item_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] blue_out;
      logic [7:0] green_out;
      logic [7:0] red_out;
      logic       end_of_row;
      logic       end_of_frame;
   } rsp_item_type;

   // request codes
   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_PULL = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_PIXEL = 2'd0;
   localparam logic [1:0] KIND_PAD   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // commands from the front to the back
   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_PIXEL,
      CMD_PAD,
      CMD_ERROR
   } cmd_op_type;

   // enough for the widest line store
   localparam int ADDR_BITS = 13;

   typedef struct packed {
      cmd_op_type           op;
      logic [ADDR_BITS-1:0] addr;
      logic [23:0]          pixel;
      logic                 last;
      logic                 eof;
   } cmd_type;

   typedef struct packed {
      logic [6:0]  scale_factor;
      logic [10:0] image_width;
      logic [12:0] image_height;
   } cfg_type;

   // register map (word index)
   localparam int         PADDR_BITS = 4;
   localparam logic [1:0] CSR_SCALE  = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;

   localparam logic [6:0]  SCALE_RESET  = 7'd1;
   localparam logic [10:0] WIDTH_RESET  = 11'd1;
   localparam logic [12:0] HEIGHT_RESET = 13'd1;

endpackage

// ===== src/integer_pixel_upscaler.sv =====
// Top level of the integer pixel upscaler: register port, front, queue, back.
//
// Nearest-neighbor integer upscaler for 24-bit pixel rows (BMP row layout).
// Input channel (push/full, req_item): req_type 0 pushes a pixel into the
// line store, req_type 1 pulls the next output item once a full row is held.
// Result channel (empty/pop, rsp_item): pixels repeated scale times, then the
// zero padding bytes of each output row; a row is sent scale times. A pixel
// pushed while a row drains is dropped and reported as an error item. A pull
// with no row ready is taken and gives no item.
// Register port: APB-style, scale_factor at 0x0, image_width at 0x4,
// image_height at 0x8; write only while no item is in flight.
// Throughput: one item per clock while full is low, limited by the single line
// store port. A result reaches rsp_item through the command queue, the read
// stage and the result queue.
// When the receiver stalls, up to four results wait in the result queue and
// two commands in the command queue; full rises once both are taken up.
// Reset clears all counters and queues and sets all registers to 1; the line
// store is not cleared and needs no clearing pass.
module integer_pixel_upscaler #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_SCALE  = 100
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  upsc_pkg::req_item_type            req_item,
   output logic                              empty,
   input  logic                              pop,
   output upsc_pkg::rsp_item_type            rsp_item,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [upsc_pkg::PADDR_BITS-1:0]   paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   upsc_pkg::cfg_type cfg_ff, cfg_in;
   logic              csr_wr;
   logic              item_en;
   logic              front_cmd_valid;
   upsc_pkg::cmd_type front_cmd;
   upsc_pkg::cmd_type queue_cmd;
   logic              queue_empty;
   logic              back_pop;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (paddr[3:2])
            upsc_pkg::CSR_SCALE:  cfg_in.scale_factor = pwdata[6:0];
            upsc_pkg::CSR_WIDTH:  cfg_in.image_width  = pwdata[10:0];
            upsc_pkg::CSR_HEIGHT: cfg_in.image_height = pwdata[12:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         upsc_pkg::CSR_SCALE:  prdata = {25'd0, cfg_ff.scale_factor};
         upsc_pkg::CSR_WIDTH:  prdata = {21'd0, cfg_ff.image_width};
         upsc_pkg::CSR_HEIGHT: prdata = {19'd0, cfg_ff.image_height};
         default:              prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_factor <= upsc_pkg::SCALE_RESET;
         cfg_ff.image_width  <= upsc_pkg::WIDTH_RESET;
         cfg_ff.image_height <= upsc_pkg::HEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign item_en = push && !full;

   upsc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_SCALE  (MAX_SCALE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .item_en   (item_en),
      .req_item  (req_item),
      .cfg       (cfg_ff),
      .cmd_valid (front_cmd_valid),
      .cmd       (front_cmd)
   );

   upsc_fifo #(
      .DEPTH (2),
      .WIDTH ($bits(upsc_pkg::cmd_type))
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_cmd_valid),
      .wr_data (front_cmd),
      .rd_en   (back_pop),
      .rd_data (queue_cmd),
      .full    (full),
      .empty   (queue_empty),
      .count   ()
   );

   upsc_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!queue_empty),
      .cmd       (queue_cmd),
      .cmd_pop   (back_pop),
      .pop       (pop),
      .empty     (empty),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== src/upsc_fifo.sv =====
// Small register FIFO used for the command queue and the result queue.
module upsc_fifo #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [WIDTH-1:0]             wr_data,
   input  logic                         rd_en,
   output logic [WIDTH-1:0]             rd_data,
   output logic                         full,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNTW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_wr, do_rd})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== src/upsc_front.sv =====
// Front end: classifies items, tracks fill and drain counters, issues commands.
module upsc_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_SCALE  = 100
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_en,
   input  upsc_pkg::req_item_type req_item,
   input  upsc_pkg::cfg_type     cfg,
   output logic                  cmd_valid,
   output upsc_pkg::cmd_type     cmd
);

   localparam int CW = ($clog2(MAX_WIDTH+1)  < 2) ? 2 : $clog2(MAX_WIDTH+1);
   localparam int SW = ($clog2(MAX_SCALE+1)  < 2) ? 2 : $clog2(MAX_SCALE+1);
   localparam int RW = ($clog2(MAX_HEIGHT+1) < 2) ? 2 : $clog2(MAX_HEIGHT+1);

   logic [SW-1:0] s_eff;
   logic [CW-1:0] w_eff;
   logic [RW-1:0] h_eff;
   logic [3:0]    pad_prod;
   logic [1:0]    pads;

   logic          row_ready_ff, row_ready_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] drain_ff, drain_in;
   logic [SW-1:0] copy_ff, copy_in;
   logic [SW-1:0] repeat_ff, repeat_in;
   logic [1:0]    pad_ff, pad_in;
   logic [RW-1:0] rows_ff, rows_in;

   logic [CW-1:0] fill_next, drain_next;
   logic [SW-1:0] copy_next, repeat_next;
   logic [1:0]    pad_next;
   logic [RW-1:0] rows_next;
   logic          last;

   // out-of-range register values act as 1 or as the maximum
   always_comb begin
      if (cfg.scale_factor == '0) begin
         s_eff = SW'(1);
      end else if (32'(cfg.scale_factor) > 32'(MAX_SCALE)) begin
         s_eff = SW'(MAX_SCALE);
      end else begin
         s_eff = SW'(cfg.scale_factor);
      end
      if (cfg.image_width == '0) begin
         w_eff = CW'(1);
      end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = CW'(cfg.image_width);
      end
      if (cfg.image_height == '0) begin
         h_eff = RW'(1);
      end else if (32'(cfg.image_height) > 32'(MAX_HEIGHT)) begin
         h_eff = RW'(MAX_HEIGHT);
      end else begin
         h_eff = RW'(cfg.image_height);
      end
   end

   // row byte count mod 4 only needs the low bits of width and scale
   assign pad_prod = {2'b00, w_eff[1:0]} * {2'b00, s_eff[1:0]};
   assign pads     = pad_prod[1:0];

   always_comb begin
      row_ready_in = row_ready_ff;
      fill_in      = fill_ff;
      drain_in     = drain_ff;
      copy_in      = copy_ff;
      repeat_in    = repeat_ff;
      pad_in       = pad_ff;
      rows_in      = rows_ff;
      cmd_valid    = 1'b0;
      cmd.op       = upsc_pkg::CMD_WRITE;
      cmd.addr     = upsc_pkg::ADDR_BITS'(fill_ff);
      cmd.pixel    = {req_item.red_in, req_item.green_in, req_item.blue_in};
      cmd.last     = 1'b0;
      cmd.eof      = 1'b0;
      fill_next    = fill_ff + 1'b1;
      copy_next    = copy_ff + 1'b1;
      pad_next     = pad_ff + 1'b1;
      repeat_next  = repeat_ff + 1'b1;
      rows_next    = rows_ff + 1'b1;
      drain_next   = drain_ff;
      last         = 1'b0;

      if (item_en) begin
         if (req_item.req_type == upsc_pkg::REQ_PUSH) begin
            cmd_valid = 1'b1;
            if (row_ready_ff) begin
               // row still draining: drop the pixel
               cmd.op = upsc_pkg::CMD_ERROR;
            end else if (fill_next >= w_eff) begin
               fill_in      = '0;
               row_ready_in = 1'b1;
            end else begin
               fill_in = fill_next;
            end
         end else if (row_ready_ff) begin
            cmd_valid = 1'b1;
            if (drain_ff < w_eff) begin
               cmd.op   = upsc_pkg::CMD_PIXEL;
               cmd.addr = upsc_pkg::ADDR_BITS'(drain_ff);
               if (copy_next >= s_eff) begin
                  copy_in    = '0;
                  drain_next = drain_ff + 1'b1;
               end else begin
                  copy_in = copy_next;
               end
               drain_in = drain_next;
               last     = (drain_next >= w_eff) && (pads == 2'd0);
            end else begin
               cmd.op = upsc_pkg::CMD_PAD;
               pad_in = pad_next;
               last   = (pad_next >= pads);
            end

            if (last) begin
               drain_in = '0;
               copy_in  = '0;
               pad_in   = '0;
               if (repeat_next >= s_eff) begin
                  repeat_in    = '0;
                  row_ready_in = 1'b0;
                  if (rows_next >= h_eff) begin
                     cmd.eof = 1'b1;
                     rows_in = '0;
                  end else begin
                     rows_in = rows_next;
                  end
               end else begin
                  repeat_in = repeat_next;
               end
            end
            cmd.last = last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ready_ff <= 1'b0;
         fill_ff      <= '0;
         drain_ff     <= '0;
         copy_ff      <= '0;
         repeat_ff    <= '0;
         pad_ff       <= '0;
         rows_ff      <= '0;
      end else begin
         row_ready_ff <= row_ready_in;
         fill_ff      <= fill_in;
         drain_ff     <= drain_in;
         copy_ff      <= copy_in;
         repeat_ff    <= repeat_in;
         pad_ff       <= pad_in;
         rows_ff      <= rows_in;
      end
   end

endmodule

// ===== src/upsc_back.sv =====
// Back end: line store, read stage and result queue.
module upsc_back #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  upsc_pkg::cmd_type      cmd,
   output logic                   cmd_pop,
   input  logic                   pop,
   output logic                   empty,
   output upsc_pkg::rsp_item_type rsp_item
);

   localparam int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int OUT_DEPTH = 4;
   localparam int OCW       = $clog2(OUT_DEPTH+1);

   logic [23:0]            line_mem [MAX_WIDTH];
   logic [23:0]            rd_data_ff;
   upsc_pkg::cmd_type      s1_cmd_ff;
   logic                   s1_valid_ff, s1_valid_in;
   logic [OCW-1:0]         out_count;
   logic                   room;
   logic                   out_full;
   upsc_pkg::rsp_item_type s1_rsp;

   // reserve a queue slot for the item in the read stage
   assign room        = !out_full &&
                        (({1'b0, out_count} + (OCW+1)'(s1_valid_ff)) < (OCW+1)'(OUT_DEPTH));
   assign cmd_pop     = cmd_valid && ((cmd.op == upsc_pkg::CMD_WRITE) || room);
   assign s1_valid_in = cmd_pop && (cmd.op != upsc_pkg::CMD_WRITE);

   always_ff @(posedge clock) begin
      if (cmd_pop && (cmd.op == upsc_pkg::CMD_WRITE)) begin
         line_mem[cmd.addr[AW-1:0]] <= cmd.pixel;
      end
      if (cmd_pop) begin
         rd_data_ff <= line_mem[cmd.addr[AW-1:0]];
         s1_cmd_ff  <= cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_comb begin
      s1_rsp.blue_out     = 8'd0;
      s1_rsp.green_out    = 8'd0;
      s1_rsp.red_out      = 8'd0;
      s1_rsp.end_of_row   = s1_cmd_ff.last;
      s1_rsp.end_of_frame = s1_cmd_ff.eof;
      unique case (s1_cmd_ff.op)
         upsc_pkg::CMD_PIXEL: begin
            s1_rsp.out_kind  = upsc_pkg::KIND_PIXEL;
            s1_rsp.blue_out  = rd_data_ff[7:0];
            s1_rsp.green_out = rd_data_ff[15:8];
            s1_rsp.red_out   = rd_data_ff[23:16];
         end
         upsc_pkg::CMD_PAD: begin
            s1_rsp.out_kind = upsc_pkg::KIND_PAD;
         end
         default: begin
            s1_rsp.out_kind = upsc_pkg::KIND_ERROR;
         end
      endcase
   end

   upsc_fifo #(
      .DEPTH (OUT_DEPTH),
      .WIDTH ($bits(upsc_pkg::rsp_item_type))
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (s1_valid_ff),
      .wr_data (s1_rsp),
      .rd_en   (pop),
      .rd_data (rsp_item),
      .full    (out_full),
      .empty   (empty),
      .count   (out_count)
   );

endmodule

// ===== tb/sv/upscaler_checker.sv =====
`timescale 1ns / 1ps
// Upscaler checker: tracks the registers, predicts every result item and compares it.
module upscaler_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  logic                            full,
   input  upsc_pkg::req_item_type          req_item,
   input  logic                            empty,
   input  logic                            pop,
   input  upsc_pkg::rsp_item_type          rsp_item,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic                            pready,
   input  logic [upsc_pkg::PADDR_BITS-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output int                              fail_count,
   output int                              pending_count,
   output logic                            row_draining
);

   localparam int unsigned LINE_DEPTH  = 1024;
   localparam int unsigned HEIGHT_CAP  = 4096;
   localparam int unsigned SCALE_CAP   = 100;

   logic [6:0]  scale_reg;
   logic [10:0] width_reg;
   logic [12:0] height_reg;

   logic [23:0] line_store [LINE_DEPTH];
   logic [10:0] fill_col;
   logic        row_ready;
   logic [6:0]  repeat_idx;
   logic [10:0] drain_col;
   logic [6:0]  copy_idx;
   logic [1:0]  pad_idx;
   logic [11:0] row_cnt;

   upsc_pkg::rsp_item_type expected_items [$];
   int                     results_seen;

   initial fail_count = 0;

   // zero acts as one, anything above the cap acts as the cap
   function automatic int unsigned bounded(input int unsigned v, input int unsigned cap);
      if (v == 0)
         return 1;
      return (v > cap) ? cap : v;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at result %0d: %s", results_seen, msg);
      fail_count++;
   endtask

   task automatic clear_model();
      scale_reg  = upsc_pkg::SCALE_RESET;
      width_reg  = upsc_pkg::WIDTH_RESET;
      height_reg = upsc_pkg::HEIGHT_RESET;
      fill_col   = '0;
      row_ready  = 1'b0;
      repeat_idx = '0;
      drain_col  = '0;
      copy_idx   = '0;
      pad_idx    = '0;
      row_cnt    = '0;
      results_seen = 0;
      expected_items.delete();
   endtask

   task automatic write_register(input logic [upsc_pkg::PADDR_BITS-1:0] addr,
                                 input logic [31:0] data);
      unique case (addr[upsc_pkg::PADDR_BITS-1:2])
         upsc_pkg::CSR_SCALE: begin
            scale_reg = data[6:0];
         end
         upsc_pkg::CSR_WIDTH: begin
            width_reg = data[10:0];
         end
         upsc_pkg::CSR_HEIGHT: begin
            height_reg = data[12:0];
         end
         default: ;
      endcase
   endtask

   task automatic predict_request(input upsc_pkg::req_item_type it);
      int unsigned            s, w, h, pads;
      logic [23:0]            pix;
      logic                   at_last, at_frame;
      upsc_pkg::rsp_item_type r;
      s = bounded(scale_reg, SCALE_CAP);
      w = bounded(width_reg, LINE_DEPTH);
      h = bounded(height_reg, HEIGHT_CAP);
      pads = (w * s) & 3;
      pix = '0;
      at_last = 1'b0;
      at_frame = 1'b0;
      r = '0;

      if (it.req_type == upsc_pkg::REQ_PUSH) begin
         // a pixel pushed while the row still drains is dropped
         if (row_ready) begin
            r.out_kind = upsc_pkg::KIND_ERROR;
            expected_items.push_back(r);
            return;
         end
         if (fill_col < LINE_DEPTH)
            line_store[fill_col[9:0]] = {it.red_in, it.green_in, it.blue_in};
         fill_col = fill_col + 11'd1;
         if (fill_col >= w) begin
            fill_col = '0;
            row_ready = 1'b1;
         end
         return;
      end

      if (!row_ready)
         return;

      if (drain_col < w) begin
         r.out_kind = upsc_pkg::KIND_PIXEL;
         if (drain_col < LINE_DEPTH)
            pix = line_store[drain_col[9:0]];
         copy_idx = copy_idx + 7'd1;
         if (copy_idx >= s) begin
            copy_idx = '0;
            drain_col = drain_col + 11'd1;
         end
         at_last = (drain_col >= w) && (pads == 0);
      end else begin
         // padding phase; ends after one byte even when none is due
         r.out_kind = upsc_pkg::KIND_PAD;
         pad_idx = pad_idx + 2'd1;
         at_last = (pad_idx >= pads);
      end

      if (at_last) begin
         drain_col = '0;
         copy_idx  = '0;
         pad_idx   = '0;
         repeat_idx = repeat_idx + 7'd1;
         if (repeat_idx >= s) begin
            repeat_idx = '0;
            row_ready = 1'b0;
            if (row_cnt + 1 >= h) begin
               at_frame = 1'b1;
               row_cnt = '0;
            end else begin
               row_cnt = row_cnt + 12'd1;
            end
         end
      end

      r.blue_out     = pix[7:0];
      r.green_out    = pix[15:8];
      r.red_out      = pix[23:16];
      r.end_of_row   = at_last;
      r.end_of_frame = at_frame;
      expected_items.push_back(r);
   endtask

   task automatic check_result(input upsc_pkg::rsp_item_type got);
      upsc_pkg::rsp_item_type want;
      if (expected_items.size() == 0) begin
         report_mismatch("result item arrived with none expected");
         return;
      end
      want = expected_items.pop_front();
      if (got.out_kind !== want.out_kind)
         report_mismatch($sformatf("out_kind got %0d want %0d", got.out_kind, want.out_kind));
      if (got.blue_out !== want.blue_out)
         report_mismatch($sformatf("blue_out got %h want %h", got.blue_out, want.blue_out));
      if (got.green_out !== want.green_out)
         report_mismatch($sformatf("green_out got %h want %h", got.green_out, want.green_out));
      if (got.red_out !== want.red_out)
         report_mismatch($sformatf("red_out got %h want %h", got.red_out, want.red_out));
      if (got.end_of_row !== want.end_of_row)
         report_mismatch($sformatf("end_of_row got %b want %b",
                                   got.end_of_row, want.end_of_row));
      if (got.end_of_frame !== want.end_of_frame)
         report_mismatch($sformatf("end_of_frame got %b want %b",
                                   got.end_of_frame, want.end_of_frame));
   endtask

   // results popped now always come from earlier items, so compare before predicting
   always @(posedge clock) begin
      if (reset) begin
         clear_model();
      end else begin
         if (psel && penable && pwrite && pready)
            write_register(paddr, pwdata);
         if (pop && !empty) begin
            check_result(rsp_item);
            results_seen++;
         end
         if (push && !full)
            predict_request(req_item);
      end
      pending_count = expected_items.size();
      row_draining  = row_ready;
   end

endmodule

// ===== tb/sv/tb_integer_pixel_upscaler.sv =====
`timescale 1ns / 1ps
// Testbench top for the integer pixel upscaler: clock, reset, stimulus and verdict.
module tb_integer_pixel_upscaler;

   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int QUIET_CYCLES = 8;
   localparam int LONG_HOLD_CYCLES = 400;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            push;
   logic                            full;
   upsc_pkg::req_item_type          req_item;
   logic                            empty;
   logic                            pop;
   upsc_pkg::rsp_item_type          rsp_item;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [upsc_pkg::PADDR_BITS-1:0] paddr;
   logic [31:0]                     pwdata;
   logic [31:0]                     prdata;
   logic                            pready;

   int   fail_count;
   int   pending_count;
   logic row_draining;
   bit   sender_idles = 1'b1;
   bit   receiver_idles = 1'b1;
   bit   long_hold = 1'b0;
   int   cycle_count = 0;

   integer_pixel_upscaler i_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   upscaler_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_item      (req_item),
      .empty         (empty),
      .pop           (pop),
      .rsp_item      (rsp_item),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .pready        (pready),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .row_draining  (row_draining)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic upsc_pkg::req_item_type make_item(input logic kind,
                                                        input logic [7:0] b,
                                                        input logic [7:0] g,
                                                        input logic [7:0] r);
      upsc_pkg::req_item_type it;
      it.req_type = kind;
      it.blue_in  = b;
      it.green_in = g;
      it.red_in   = r;
      return it;
   endfunction

   function automatic upsc_pkg::req_item_type random_pixel();
      return make_item(upsc_pkg::REQ_PUSH, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endfunction

   // pull items carry random data too, the block ignores it
   function automatic upsc_pkg::req_item_type pull_item();
      return make_item(upsc_pkg::REQ_PULL, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endfunction

   // called on a falling edge; returns on the falling edge after the item is taken
   task automatic send_item(input upsc_pkg::req_item_type it);
      int unsigned gap;
      gap = sender_idles ? $urandom_range(0, 14) : 0;
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item <= it;
      push <= 1'b1;
      do @(posedge clock); while (full);
      @(negedge clock);
   endtask

   task automatic finish_row();
      while (row_draining)
         send_item(pull_item());
   endtask

   // items with no result may still be in the pipe when the last result arrives
   task automatic wait_quiet();
      push <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_geometry(input int unsigned s, input int unsigned w,
                               input int unsigned h);
      wait_quiet();
      write_reg(upsc_pkg::CSR_SCALE, s);
      write_reg(upsc_pkg::CSR_WIDTH, w);
      write_reg(upsc_pkg::CSR_HEIGHT, h);
   endtask

   // mostly whole rows with random pixels, drained with the odd dropped push,
   // plus loose items of either kind
   task automatic random_phase(input int unsigned s, input int unsigned w,
                               input int unsigned h, input int unsigned count);
      int unsigned done;
      logic        kind;
      finish_row();
      set_geometry(s, w, h);
      done = 0;
      while (done < count) begin
         sender_idles   = ($urandom_range(0, 3) != 0);
         receiver_idles = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) != 0) begin
            repeat (w) begin
               send_item(random_pixel());
               done++;
            end
            while (row_draining) begin
               if ($urandom_range(0, 19) == 0)
                  send_item(random_pixel());
               else
                  send_item(pull_item());
               done++;
            end
         end else begin
            kind = ($urandom_range(0, 1) != 0) ? upsc_pkg::REQ_PULL : upsc_pkg::REQ_PUSH;
            if (kind == upsc_pkg::REQ_PUSH) begin
               send_item(random_pixel());
               done++;
            end else begin
               send_item(pull_item());
            end
         end
      end
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   initial begin : receiver
      int unsigned wait_cycles;
      pop = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         wait_cycles = receiver_idles ? $urandom_range(0, 14) : 0;
         if (long_hold) begin
            wait_cycles = wait_cycles + LONG_HOLD_CYCLES;
            long_hold = 1'b0;
         end
         if (wait_cycles != 0) begin
            pop <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      reset    = 1'b1;
      push     = 1'b0;
      req_item = '0;
      psel     = 1'b0;
      penable  = 1'b0;
      pwrite   = 1'b0;
      paddr    = '0;
      pwdata   = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset geometry 1 x 1 x 1: one pixel plus one pad byte per row, every row ends the frame
      send_item(pull_item());
      send_item(make_item(upsc_pkg::REQ_PUSH, 8'hFF, 8'hFF, 8'hFF));
      send_item(make_item(upsc_pkg::REQ_PUSH, 8'h00, 8'h00, 8'h00));
      send_item(pull_item());
      send_item(pull_item());
      send_item(pull_item());
      send_item(make_item(upsc_pkg::REQ_PUSH, 8'h00, 8'h00, 8'h00));
      finish_row();
      send_item(make_item(upsc_pkg::REQ_PUSH, 8'hA5, 8'h5A, 8'hC3));
      finish_row();

      // width lowered mid-row with no padding due: one pad byte closes the row
      set_geometry(4, 2, 2);
      send_item(make_item(upsc_pkg::REQ_PUSH, 8'h0F, 8'hF0, 8'h3C));
      send_item(make_item(upsc_pkg::REQ_PUSH, 8'hC3, 8'h96, 8'h69));
      repeat (5) send_item(pull_item());
      wait_quiet();
      write_reg(upsc_pkg::CSR_WIDTH, 1);
      finish_row();

      // zero registers act as one
      set_geometry(0, 0, 0);
      send_item(make_item(upsc_pkg::REQ_PUSH, 8'h55, 8'hAA, 8'h55));
      send_item(make_item(upsc_pkg::REQ_PUSH, 8'hAA, 8'h55, 8'hAA));
      finish_row();

      // receiver holds off while pulls keep coming, so full must rise
      set_geometry(4, 8, 5);
      sender_idles = 1'b0;
      repeat (8) send_item(random_pixel());
      long_hold = 1'b1;
      repeat (80) send_item(pull_item());
      finish_row();
      sender_idles = 1'b1;

      random_phase(3, 1, 2, 60);
      repeat (6)
         random_phase($urandom_range(1, 5), $urandom_range(1, 9), $urandom_range(1, 4), 50);

      // out-of-range scale acts as the largest: the first output row holds 100 pixels,
      // then a smaller scale closes the row early
      finish_row();
      set_geometry(127, 1, 8191);
      sender_idles = 1'b0;
      send_item(random_pixel());
      repeat (101) send_item(pull_item());
      wait_quiet();
      write_reg(upsc_pkg::CSR_SCALE, 1);
      finish_row();
      sender_idles = 1'b1;

      random_phase(2, 3, 3, 60);

      wait_quiet();
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/upsc_pkg.sv
src/upsc_fifo.sv
src/upsc_front.sv
src/upsc_back.sv
src/integer_pixel_upscaler.sv
tb/sv/upscaler_checker.sv
tb/sv/tb_integer_pixel_upscaler.sv
